@@ hdl/lobl_pkg.sv @@
// Package for the price-level order book: table sizes, status and kind codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package lobl_pkg;

   localparam int ORDER_CAPACITY = 1024;
   localparam int LEVEL_CAPACITY = 256;
   localparam int OIDX_W = $clog2(ORDER_CAPACITY);
   localparam int LIDX_W = $clog2(LEVEL_CAPACITY);
   localparam int IDX_W = (OIDX_W > LIDX_W) ? OIDX_W : LIDX_W;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
   localparam logic [2:0] ST_TRADE_EXCEED = 3'd2;
   localparam logic [2:0] ST_ORDERS_FULL  = 3'd3;
   localparam logic [2:0] ST_LEVELS_FULL  = 3'd4;
   localparam logic [2:0] ST_INCONSISTENT = 3'd5;

   localparam logic [1:0] K_NEW    = 2'd0;
   localparam logic [1:0] K_DELETE = 2'd1;
   localparam logic [1:0] K_MODIFY = 2'd2;
   localparam logic [1:0] K_TRADE  = 2'd3;

   // Operand sets for a level operation.
   localparam logic [1:0] LOP_NEW   = 2'd0;
   localparam logic [1:0] LOP_OLD   = 2'd1;
   localparam logic [1:0] LOP_TRADE = 2'd2;

   // Order table write operations.
   localparam logic [2:0] OW_NONE  = 3'd0;
   localparam logic [2:0] OW_NEW   = 3'd1;
   localparam logic [2:0] OW_MOD   = 3'd2;
   localparam logic [2:0] OW_TRADE = 3'd3;
   localparam logic [2:0] OW_KILL  = 3'd4;

   // Scan kinds.
   localparam logic [1:0] SK_ORD  = 2'd0;
   localparam logic [1:0] SK_LVL  = 2'd1;
   localparam logic [1:0] SK_BEST = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic        sell;
      logic [31:0] price;
      logic [31:0] qty;
   } order_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] price;
      logic [31:0] qty;
   } level_type;

   typedef struct packed {
      logic       load;
      logic       ostart;
      logic       lstart;
      logic [1:0] lop;
      logic       lapply;
      logic       bstart;
      logic [2:0] owr;
      logic       out_load;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic       clearing;
      logic       done;
      logic [1:0] kind;
      logic       ofound;
      logic       ofree;
      logic       qty_short;
      logic [2:0] lstat;
      logic       out_full;
   } stat_type;

endpackage

@@ hdl/limit_order_book_levels.sv @@
// Price-level order book, top level: controller plus datapath. Uses lobl_pkg.
// The order scan, the level scans (one, two for a modify, none on early errors) and the
// best-level scan run in turn before the result is loaded. One item at a time: the next
// transfer can be taken in the cycle after the result is loaded.
// Reset is synchronous; after it all three tables are cleared in one pass.
module limit_order_book_levels
   import lobl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // order_key [63:0], is_sell [64], amount [96:65], limit_price [128:97], zero fill
   input  logic [135:0] req_tdata,
   // kind [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status [2:0], bid_price [34:3], bid_amount [66:35], ask_price [98:67],
   // ask_amount [130:99], zero fill
   output logic [135:0] rsp_tdata
);

   cmd_type     cmd;
   stat_type    stat;
   logic [2:0]  rsp_status;
   logic [31:0] bid_price, bid_amount, ask_price, ask_amount;

   lobl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lobl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_kind        (req_tuser),
      .in_order_key   (req_tdata[63:0]),
      .in_is_sell     (req_tdata[64]),
      .in_amount      (req_tdata[96:65]),
      .in_limit_price (req_tdata[128:97]),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .out_status     (rsp_status),
      .out_bid_price  (bid_price),
      .out_bid_amount (bid_amount),
      .out_ask_price  (ask_price),
      .out_ask_amount (ask_amount)
   );

   assign rsp_tdata = {5'd0, ask_amount, ask_price, bid_amount, bid_price, rsp_status};

   // No transfer is taken while the order table is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ostart, cmd.lstart, cmd.bstart}))
      else $error("two scans started at once");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_INCONSISTENT)
      else $error("result status out of range");

   // A level never holds zero quantity, so an empty side reports price zero too.
   a_empty_bid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[66:35] == 32'd0) |-> rsp_tdata[34:3] == 32'd0)
      else $error("bid price without quantity");

endmodule

@@ hdl/lobl_ctrl.sv @@
// Controller state machine of the order book: sequences the order scan,
// level scans and updates, best-level scan and result load. Uses lobl_pkg.
module lobl_ctrl
   import lobl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_OWAIT = 3'd1;
   localparam logic [2:0] S_LWAIT = 3'd2;
   localparam logic [2:0] S_LWAIT2 = 3'd3;
   localparam logic [2:0] S_BWAIT = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      cmd        = '0;
      cmd.status = st_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = !stat.clearing;
            if (req_tvalid && !stat.clearing) begin
               cmd.load   = 1'b1;
               cmd.ostart = 1'b1;
               st_in      = ST_OK;
               state_in   = S_OWAIT;
            end
         end
         S_OWAIT: begin
            if (stat.done) begin
               if (stat.kind == K_NEW) begin
                  if (!stat.ofound && !stat.ofree) begin
                     st_in      = ST_ORDERS_FULL;
                     cmd.bstart = 1'b1;
                     state_in   = S_BWAIT;
                  end else begin
                     cmd.lstart = 1'b1;
                     cmd.lop    = LOP_NEW;
                     state_in   = S_LWAIT;
                  end
               end else if (!stat.ofound) begin
                  st_in      = ST_NOT_FOUND;
                  cmd.bstart = 1'b1;
                  state_in   = S_BWAIT;
               end else if (stat.kind == K_TRADE && stat.qty_short) begin
                  st_in      = ST_TRADE_EXCEED;
                  cmd.bstart = 1'b1;
                  state_in   = S_BWAIT;
               end else begin
                  cmd.lstart = 1'b1;
                  cmd.lop    = (stat.kind == K_TRADE) ? LOP_TRADE : LOP_OLD;
                  state_in   = S_LWAIT;
               end
            end
         end
         S_LWAIT: begin
            if (stat.done) begin
               cmd.lapply = 1'b1;
               st_in      = stat.lstat;
               case (stat.kind)
                  K_NEW: begin
                     if (stat.lstat == ST_OK && !stat.ofound) begin
                        cmd.owr = OW_NEW;
                     end
                     cmd.bstart = 1'b1;
                     state_in   = S_BWAIT;
                  end
                  K_DELETE: begin
                     cmd.owr    = OW_KILL;
                     cmd.bstart = 1'b1;
                     state_in   = S_BWAIT;
                  end
                  K_MODIFY: begin
                     // The old quantity leaves its level before the new one is added.
                     cmd.lstart = 1'b1;
                     cmd.lop    = LOP_NEW;
                     state_in   = S_LWAIT2;
                  end
                  default: begin
                     cmd.owr    = OW_TRADE;
                     cmd.bstart = 1'b1;
                     state_in   = S_BWAIT;
                  end
               endcase
            end
         end
         S_LWAIT2: begin
            if (stat.done) begin
               cmd.lapply = 1'b1;
               if (stat.lstat != ST_OK) begin
                  st_in   = stat.lstat;
                  cmd.owr = OW_KILL;
               end else begin
                  cmd.owr = OW_MOD;
               end
               cmd.bstart = 1'b1;
               state_in   = S_BWAIT;
            end
         end
         S_BWAIT: begin
            if (stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!stat.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/lobl_dp.sv @@
// Datapath of the order book: order and level memories, the shared scan
// counter and compare stage, table updates and the result register. Uses lobl_pkg.
module lobl_dp
   import lobl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   in_kind,
   input  logic [63:0]  in_order_key,
   input  logic         in_is_sell,
   input  logic [31:0]  in_amount,
   input  logic [31:0]  in_limit_price,
   input  cmd_type      cmd,
   output stat_type     stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   out_status,
   output logic [31:0]  out_bid_price,
   output logic [31:0]  out_bid_amount,
   output logic [31:0]  out_ask_price,
   output logic [31:0]  out_ask_amount
);

   order_type ord_mem [ORDER_CAPACITY];
   level_type buy_mem [LEVEL_CAPACITY];
   level_type sell_mem [LEVEL_CAPACITY];

   // Latched request.
   logic [1:0]  kind_ff;
   logic [63:0] key_ff;
   logic        sell_ff;
   logic [31:0] amt_ff, price_ff;

   // Order scan results.
   logic              ofound_ff, ofree_ff, osell_ff;
   logic [OIDX_W-1:0] oidx_ff, fidx_ff;
   logic [31:0]       oprice_ff, oqty_ff;

   // Level operation operands and scan results.
   logic              lside_ff, ladd_ff, lfound_ff, lfree_ff;
   logic [31:0]       lprice_ff, lamt_ff, lqty_ff;
   logic [LIDX_W-1:0] lidx_ff, lfidx_ff;

   // Best-level trackers.
   logic        bh_ff, ah_ff;
   logic [31:0] bp_ff, bq_ff, ap_ff, aq_ff;

   // Scan sequencing.
   logic             scan_ff, pipe_ff, plast_ff, done_ff;
   logic [1:0]       sk_ff;
   logic [IDX_W-1:0] cnt_ff, pidx_ff;
   logic             is_last;

   logic              clr_ff;
   logic [OIDX_W-1:0] ccnt_ff;

   order_type ord_rd_ff;
   level_type buy_rd_ff, sell_rd_ff, lrd;

   logic        out_v_ff;
   logic [2:0]  ost_ff;
   logic [31:0] obp_ff, obq_ff, oap_ff, oaq_ff;

   // Write-side logic.
   logic              ow_en;
   logic [OIDX_W-1:0] ow_addr;
   order_type         ow_data;
   logic [31:0]       trade_left;

   logic              lzero, lw_en;
   logic [2:0]        lstat;
   logic [32:0]       lsum;
   logic [31:0]       lsat, ldiff;
   logic [LIDX_W-1:0] lw_addr;
   level_type         lw_data;

   assign is_last = (sk_ff == SK_ORD) ? (cnt_ff == IDX_W'(ORDER_CAPACITY - 1))
                                      : (cnt_ff == IDX_W'(LEVEL_CAPACITY - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= 1'b0;
         pipe_ff  <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         sk_ff    <= SK_ORD;
         clr_ff   <= 1'b1;
         ccnt_ff  <= '0;
      end else begin
         pipe_ff  <= scan_ff;
         plast_ff <= scan_ff && is_last;
         done_ff  <= pipe_ff && plast_ff;
         if (cmd.ostart || cmd.lstart || cmd.bstart) begin
            scan_ff <= 1'b1;
            cnt_ff  <= '0;
            sk_ff   <= cmd.ostart ? SK_ORD : (cmd.lstart ? SK_LVL : SK_BEST);
         end else if (scan_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (is_last) begin
               scan_ff <= 1'b0;
            end
         end
         if (clr_ff) begin
            ccnt_ff <= ccnt_ff + 1'b1;
            if (ccnt_ff == OIDX_W'(ORDER_CAPACITY - 1)) begin
               clr_ff <= 1'b0;
            end
         end
      end
   end

   // Order memory: clearing pass after reset, then single writes.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         ord_mem[ccnt_ff] <= '0;
      end else if (ow_en) begin
         ord_mem[ow_addr] <= ow_data;
      end
      ord_rd_ff <= ord_mem[cnt_ff[OIDX_W-1:0]];
   end

   assign trade_left = oqty_ff - amt_ff;

   always_comb begin
      ow_en   = 1'b0;
      ow_addr = oidx_ff;
      ow_data = '0;
      case (cmd.owr)
         OW_NEW: begin
            ow_en   = 1'b1;
            ow_addr = fidx_ff;
            ow_data = '{valid: 1'b1, key: key_ff, sell: sell_ff, price: price_ff,
                        qty: amt_ff};
         end
         OW_MOD: begin
            ow_en   = 1'b1;
            ow_data = '{valid: 1'b1, key: key_ff, sell: sell_ff, price: price_ff,
                        qty: amt_ff};
         end
         OW_TRADE: begin
            ow_en   = 1'b1;
            ow_data = '{valid: (trade_left != '0), key: key_ff, sell: osell_ff,
                        price: oprice_ff, qty: trade_left};
         end
         OW_KILL: begin
            ow_en = 1'b1;
         end
         default: begin
            ow_en = 1'b0;
         end
      endcase
   end

   // Level update: add saturates, a drained level is dropped.
   assign lzero = (lamt_ff == '0);
   assign lsum  = {1'b0, lqty_ff} + {1'b0, lamt_ff};
   assign lsat  = lsum[32] ? '1 : lsum[31:0];
   assign ldiff = lqty_ff - lamt_ff;

   always_comb begin
      if (lzero) begin
         lstat = ST_OK;
      end else if (ladd_ff) begin
         lstat = (lfound_ff || lfree_ff) ? ST_OK : ST_LEVELS_FULL;
      end else begin
         lstat = (lfound_ff && !(lqty_ff < lamt_ff)) ? ST_OK : ST_INCONSISTENT;
      end
      lw_en = cmd.lapply && (lstat == ST_OK) && !lzero;
      if (ladd_ff) begin
         lw_addr = lfound_ff ? lidx_ff : lfidx_ff;
         lw_data = '{valid: 1'b1, price: lprice_ff, qty: (lfound_ff ? lsat : lamt_ff)};
      end else begin
         lw_addr = lidx_ff;
         lw_data = '{valid: (ldiff != '0), price: lprice_ff, qty: ldiff};
      end
   end

   // Level memories are cleared in the same pass as the order memory.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         buy_mem[ccnt_ff[LIDX_W-1:0]]  <= '0;
         sell_mem[ccnt_ff[LIDX_W-1:0]] <= '0;
      end else begin
         if (lw_en && !lside_ff) begin
            buy_mem[lw_addr] <= lw_data;
         end
         if (lw_en && lside_ff) begin
            sell_mem[lw_addr] <= lw_data;
         end
      end
      buy_rd_ff  <= buy_mem[cnt_ff[LIDX_W-1:0]];
      sell_rd_ff <= sell_mem[cnt_ff[LIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff;
   end

   assign lrd = lside_ff ? sell_rd_ff : buy_rd_ff;

   // Request latch, operand latch and the compare stage of every scan.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= in_kind;
         key_ff   <= in_order_key;
         sell_ff  <= in_is_sell;
         amt_ff   <= in_amount;
         price_ff <= in_limit_price;
      end
      if (cmd.ostart) begin
         ofound_ff <= 1'b0;
         ofree_ff  <= 1'b0;
      end
      if (cmd.lstart) begin
         lfound_ff <= 1'b0;
         lfree_ff  <= 1'b0;
         case (cmd.lop)
            LOP_OLD: begin
               lside_ff  <= osell_ff;
               lprice_ff <= oprice_ff;
               lamt_ff   <= oqty_ff;
               ladd_ff   <= 1'b0;
            end
            LOP_TRADE: begin
               lside_ff  <= osell_ff;
               lprice_ff <= oprice_ff;
               lamt_ff   <= amt_ff;
               ladd_ff   <= 1'b0;
            end
            default: begin
               lside_ff  <= sell_ff;
               lprice_ff <= price_ff;
               lamt_ff   <= amt_ff;
               ladd_ff   <= 1'b1;
            end
         endcase
      end
      if (cmd.bstart) begin
         bh_ff <= 1'b0;
         ah_ff <= 1'b0;
      end
      if (pipe_ff) begin
         case (sk_ff)
            SK_ORD: begin
               if (ord_rd_ff.valid && ord_rd_ff.key == key_ff && !ofound_ff) begin
                  ofound_ff <= 1'b1;
                  oidx_ff   <= pidx_ff[OIDX_W-1:0];
                  osell_ff  <= ord_rd_ff.sell;
                  oprice_ff <= ord_rd_ff.price;
                  oqty_ff   <= ord_rd_ff.qty;
               end
               if (!ord_rd_ff.valid && !ofree_ff) begin
                  ofree_ff <= 1'b1;
                  fidx_ff  <= pidx_ff[OIDX_W-1:0];
               end
            end
            SK_LVL: begin
               if (lrd.valid && lrd.price == lprice_ff && !lfound_ff) begin
                  lfound_ff <= 1'b1;
                  lidx_ff   <= pidx_ff[LIDX_W-1:0];
                  lqty_ff   <= lrd.qty;
               end
               if (!lrd.valid && !lfree_ff) begin
                  lfree_ff <= 1'b1;
                  lfidx_ff <= pidx_ff[LIDX_W-1:0];
               end
            end
            default: begin
               if (buy_rd_ff.valid &&
                   (!bh_ff || $signed(buy_rd_ff.price) > $signed(bp_ff))) begin
                  bh_ff <= 1'b1;
                  bp_ff <= buy_rd_ff.price;
                  bq_ff <= buy_rd_ff.qty;
               end
               if (sell_rd_ff.valid &&
                   (!ah_ff || $signed(sell_rd_ff.price) < $signed(ap_ff))) begin
                  ah_ff <= 1'b1;
                  ap_ff <= sell_rd_ff.price;
                  aq_ff <= sell_rd_ff.qty;
               end
            end
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ost_ff <= cmd.status;
         obp_ff <= bh_ff ? bp_ff : '0;
         obq_ff <= bh_ff ? bq_ff : '0;
         oap_ff <= ah_ff ? ap_ff : '0;
         oaq_ff <= ah_ff ? aq_ff : '0;
      end
   end

   assign rsp_tvalid     = out_v_ff;
   assign out_status     = ost_ff;
   assign out_bid_price  = obp_ff;
   assign out_bid_amount = obq_ff;
   assign out_ask_price  = oap_ff;
   assign out_ask_amount = oaq_ff;

   assign stat.clearing  = clr_ff;
   assign stat.done      = done_ff;
   assign stat.kind      = kind_ff;
   assign stat.ofound    = ofound_ff;
   assign stat.ofree     = ofree_ff;
   assign stat.qty_short = (oqty_ff < amt_ff);
   assign stat.lstat     = lstat;
   assign stat.out_full  = out_v_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for limit_order_book_levels: new, delete, modify and trade
// messages go in, and each book snapshot that comes back is checked against a predictor
// of the order and level tables. Depends on lobl_pkg and the RTL top level.

import lobl_pkg::*;

typedef struct {
   logic [1:0]  kind;
   logic [63:0] key;
   logic        sell;
   logic [31:0] amount;
   logic [31:0] price;
} book_msg_type;

typedef struct {
   logic [2:0]  status;
   logic [31:0] bid_price;
   logic [31:0] bid_amount;
   logic [31:0] ask_price;
   logic [31:0] ask_amount;
} book_snap_type;

class book_scoreboard;
   bit          ord_valid[ORDER_CAPACITY];
   bit   [63:0] ord_key[ORDER_CAPACITY];
   bit          ord_sell[ORDER_CAPACITY];
   bit   [31:0] ord_price[ORDER_CAPACITY];
   bit   [31:0] ord_qty[ORDER_CAPACITY];
   bit          lvl_valid[2][LEVEL_CAPACITY];
   bit   [31:0] lvl_price[2][LEVEL_CAPACITY];
   bit   [31:0] lvl_qty[2][LEVEL_CAPACITY];
   book_snap_type snapshots_due[$];
   int          failures;

   function int find_order(logic [63:0] key);
      for (int i = 0; i < ORDER_CAPACITY; i++)
         if (ord_valid[i] && ord_key[i] == key) return i;
      return -1;
   endfunction

   function int find_level(bit s, logic [31:0] price);
      for (int i = 0; i < LEVEL_CAPACITY; i++)
         if (lvl_valid[s][i] && lvl_price[s][i] == price) return i;
      return -1;
   endfunction

   function logic [2:0] level_add(bit s, logic [31:0] price, logic [31:0] amt);
      bit [32:0] sum;
      int i;
      if (amt == 0) return ST_OK;
      i = find_level(s, price);
      if (i >= 0) begin
         sum = lvl_qty[s][i] + amt;
         lvl_qty[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         return ST_OK;
      end
      for (i = 0; i < LEVEL_CAPACITY; i++)
         if (!lvl_valid[s][i]) begin
            lvl_valid[s][i] = 1;
            lvl_price[s][i] = price;
            lvl_qty[s][i] = amt;
            return ST_OK;
         end
      return ST_LEVELS_FULL;
   endfunction

   function logic [2:0] level_sub(bit s, logic [31:0] price, logic [31:0] amt);
      int i;
      if (amt == 0) return ST_OK;
      i = find_level(s, price);
      if (i < 0 || lvl_qty[s][i] < amt) return ST_INCONSISTENT;
      lvl_qty[s][i] -= amt;
      if (lvl_qty[s][i] == 0) lvl_valid[s][i] = 0;
      return ST_OK;
   endfunction

   // The best bid is the highest buy price, the best ask the lowest sell price.
   function void best_of(bit s, output logic [31:0] price, output logic [31:0] qty);
      bit have;
      have = 0;
      price = 0;
      qty = 0;
      for (int i = 0; i < LEVEL_CAPACITY; i++) begin
         if (!lvl_valid[s][i]) continue;
         if (!have || (s ? ($signed(lvl_price[s][i]) < $signed(price))
                         : ($signed(lvl_price[s][i]) > $signed(price)))) begin
            have = 1;
            price = lvl_price[s][i];
            qty = lvl_qty[s][i];
         end
      end
   endfunction

   function void note_message(book_msg_type m);
      book_snap_type snap;
      logic [2:0] st, add_st;
      int oi, slot;
      st = ST_OK;
      oi = find_order(m.key);
      if (m.kind == K_NEW) begin
         slot = oi;
         if (oi < 0) begin
            slot = -1;
            for (int i = 0; i < ORDER_CAPACITY && slot < 0; i++)
               if (!ord_valid[i]) slot = i;
            if (slot < 0) st = ST_ORDERS_FULL;
         end
         if (st == ST_OK) st = level_add(m.sell, m.price, m.amount);
         if (st == ST_OK && oi < 0) begin
            ord_valid[slot] = 1;
            ord_key[slot] = m.key;
            ord_sell[slot] = m.sell;
            ord_price[slot] = m.price;
            ord_qty[slot] = m.amount;
         end
      end else if (oi < 0) begin
         st = ST_NOT_FOUND;
      end else if (m.kind == K_DELETE) begin
         st = level_sub(ord_sell[oi], ord_price[oi], ord_qty[oi]);
         ord_valid[oi] = 0;
      end else if (m.kind == K_MODIFY) begin
         st = level_sub(ord_sell[oi], ord_price[oi], ord_qty[oi]);
         add_st = level_add(m.sell, m.price, m.amount);
         if (add_st != ST_OK) begin
            st = add_st;
            ord_valid[oi] = 0;
         end else begin
            ord_sell[oi] = m.sell;
            ord_price[oi] = m.price;
            ord_qty[oi] = m.amount;
         end
      end else if (ord_qty[oi] < m.amount) begin
         st = ST_TRADE_EXCEED;
      end else begin
         ord_qty[oi] -= m.amount;
         st = level_sub(ord_sell[oi], ord_price[oi], m.amount);
         if (ord_qty[oi] == 0) ord_valid[oi] = 0;
      end
      snap.status = st;
      best_of(0, snap.bid_price, snap.bid_amount);
      best_of(1, snap.ask_price, snap.ask_amount);
      snapshots_due.push_back(snap);
   endfunction

   function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   function void check_snapshot(logic [135:0] d);
      book_snap_type want;
      if (snapshots_due.size() == 0) begin
         $error("unexpected response transfer %h", d);
         failures++;
         return;
      end
      want = snapshots_due.pop_front();
      compare("status", 32'(want.status), 32'(d[2:0]));
      compare("bid_price", want.bid_price, d[34:3]);
      compare("bid_amount", want.bid_amount, d[66:35]);
      compare("ask_price", want.ask_price, d[98:67]);
      compare("ask_amount", want.ask_amount, d[130:99]);
   endfunction
endclass

module testbench;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [135:0] rsp_tdata;

   book_scoreboard book = new();
   bit             steady = 0;
   logic [63:0]    key_pool[48];
   logic [63:0]    fill_keys[$];

   limit_order_book_levels dut (.*);

   always #6 clock = ~clock;

   always @(negedge clock) rsp_tready = steady || ($urandom_range(99) >= 27);

   always @(posedge clock) begin
      book_msg_type m;
      if (!reset && req_tvalid && req_tready) begin
         m.key = req_tdata[63:0];
         m.sell = req_tdata[64];
         m.amount = req_tdata[96:65];
         m.price = req_tdata[128:97];
         m.kind = req_tuser;
         book.note_message(m);
      end
      if (!reset && rsp_tvalid && rsp_tready) book.check_snapshot(rsp_tdata);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send(logic [1:0] kind, logic [63:0] key, logic sell, logic [31:0] amount,
                       logic [31:0] price);
      while (!steady && $urandom_range(99) < 27) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = kind;
      req_tdata = {7'd0, price, amount, sell, key};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 0;
      if (r < 25) return $urandom;
      return $urandom_range(1, 1000);
   endfunction

   function automatic logic [31:0] pick_price();
      if ($urandom_range(99) < 15) return $urandom;
      return 32'($urandom_range(0, 60)) - 32'd30;
   endfunction

   function automatic logic [1:0] pick_kind();
      case ($urandom_range(3))
         0: return K_NEW;
         1: return K_DELETE;
         2: return K_MODIFY;
         default: return K_TRADE;
      endcase
   endfunction

   initial begin
      logic [63:0] k;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Unknown keys, saturation, duplicate key, zero quantity, overfill and fill.
      send(K_TRADE, 64'h1, 0, 5, 0);
      send(K_DELETE, 64'h1, 0, 0, 0);
      send(K_MODIFY, 64'h1, 1, 9, 9);
      send(K_NEW, 64'h1, 0, 10, 32'h8000_0000);
      send(K_NEW, 64'h2, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send(K_NEW, 64'h3, 1, 5, 32'h7FFF_FFFF);
      send(K_NEW, 64'h4, 0, 0, 100);
      send(K_NEW, 64'h1, 1, 3, 7);
      send(K_TRADE, 64'h1, 0, 11, 0);
      send(K_TRADE, 64'h1, 1, 4, 32'hFFFF_FFFF);
      send(K_TRADE, 64'h1, 0, 6, 0);
      send(K_DELETE, 64'h4, 0, 0, 0);
      send(K_MODIFY, 64'h2, 0, 20, 50);
      send(K_DELETE, 64'h3, 0, 0, 0);
      send(K_NEW, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF, 50);
      send(K_NEW, 64'h0, 1, 1, 32'hFFFF_FFFF);
      send(K_TRADE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
      send(K_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 50);
      send(K_TRADE, 64'h2, 0, 20, 0);
      send(K_DELETE, 64'h0, 0, 0, 0);
      send(K_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);

      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;

      // Mixed traffic on a small key and price pool so most messages hit live orders.
      for (int n = 0; n < 300; n++)
         send(pick_kind(), key_pool[$urandom_range(47)], 1'($urandom_range(1)), pick_amount(),
              pick_price());

      // Fresh orders: first enough distinct buy prices to run out of levels, then
      // enough orders to run out of order slots.
      for (int n = 0; n < 1100; n++) begin
         steady = (n >= 500 && n < 800);
         k = {$urandom, $urandom};
         fill_keys.push_back(k);
         if (n < 300) send(K_NEW, k, 0, $urandom_range(1, 1000), 32'd5000 + 32'(n));
         else send(K_NEW, k, 1'($urandom_range(1)), $urandom_range(1, 1000), pick_price());
      end
      steady = 0;

      // Modifies into new prices while the tables are full, then mixed messages of every kind.
      for (int n = 0; n < 400; n++) begin
         k = ($urandom_range(1)) ? fill_keys[$urandom_range(fill_keys.size() - 1)]
                                 : key_pool[$urandom_range(47)];
         if (n < 60)
            send(K_MODIFY, k, 1'($urandom_range(1)), $urandom_range(1, 1000), $urandom);
         else
            send(pick_kind(), k, 1'($urandom_range(1)), $urandom_range(0, 1200),
                 pick_price());
      end
      req_tvalid = 0;

      while (book.snapshots_due.size() > 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (book.failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/lobl_pkg.sv
hdl/lobl_ctrl.sv
hdl/lobl_dp.sv
hdl/limit_order_book_levels.sv
tb/testbench.sv
